@@ hdl/ttl_lru_record_cache_core_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the record cache checker
// ----------------------------------------------------------------------------
`ifndef TTL_LRU_RECORD_CACHE_CORE_ASSERT_SVH
`define TTL_LRU_RECORD_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define TLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg
// shared constants for the ttl lru record cache
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam logic [2:0] ST_MISS      = 3'd0;
  localparam logic [2:0] ST_HIT       = 3'd1;
  localparam logic [2:0] ST_HIT_SOON  = 3'd2;
  localparam logic [2:0] ST_STALE     = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_STORED    = 3'd5;
  localparam logic [2:0] ST_PROTECTED = 3'd6;
  localparam logic [2:0] ST_DISABLED  = 3'd7;

  localparam logic [1:0] CFG_MAX_ENTRIES  = 2'd0;
  localparam logic [1:0] CFG_IMMUTABLE    = 2'd1;
  localparam logic [1:0] CFG_STALE_WINDOW = 2'd2;

  localparam logic [7:0]  MAX_ENTRIES_RST  = 8'd100;
  localparam logic [15:0] STALE_WINDOW_RST = 16'd30;

  localparam logic [1:0] SRC_LOCAL  = 2'd0;
  localparam logic [1:0] SRC_PUBLIC = 2'd1;
  localparam logic [1:0] SRC_FUSED  = 2'd2;

  // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT for x below 2^32
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;
  localparam int          SOON_W        = 28;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

endpackage

@@ hdl/tlc_if.sv @@
// ----------------------------------------------------------------------------
// tlc request and response channels
// valid/ready channels carrying one request word and one response word
// ----------------------------------------------------------------------------
interface tlc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] host_key;
  logic        family;
  logic [31:0] now_sec;
  logic [30:0] ttl_sec;
  logic        negative;
  logic [1:0]  record_source;
  logic [31:0] record_handle;

  modport source (output valid, op, host_key, family, now_sec, ttl_sec, negative,
                  record_source, record_handle, input ready);
  modport sink (input valid, op, host_key, family, now_sec, ttl_sec, negative,
                record_source, record_handle, output ready);
endinterface

interface tlc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit_negative;
  logic [1:0]  hit_source;
  logic [31:0] hit_handle;
  logic [7:0]  evicted_count;

  modport source (output valid, status, hit_negative, hit_source, hit_handle,
                  evicted_count, input ready);
  modport sink (input valid, status, hit_negative, hit_source, hit_handle,
                evicted_count, output ready);
endinterface

@@ hdl/ttl_lru_record_cache_core.sv @@
// a word is handled in two slot sweeps:
// one key scan over the slot memory, then one recency read-modify-write sweep
// miss, skipped or disabled store: no sweep, key scan only
// a new request word is taken only in IDLE, after the last word's response is issued
// reset: synchronous; clears valid bits, entry count, registers to defaults
// ----------------------------------------------------------------------------
// ttl_lru_record_cache_core
// keyed record table with lru replacement and ttl classification
// ----------------------------------------------------------------------------
module ttl_lru_record_cache_core #(
  parameter int CAPACITY = tlc_pkg::CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tlc_req_if.sink      req,
  tlc_rsp_if.source    rsp,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = (IW + 1 > 8) ? IW + 1 : 8;
  localparam int DW = 131;

  typedef enum logic [2:0] {IDLE, SCAN, DECIDE, SWEEP, FIN} state_t;

  state_t state;

  logic [7:0]  max_entries;
  logic        immutable_mode;
  logic [15:0] stale_window;

  logic        op_q;
  logic [32:0] key_q;
  logic [31:0] now_q;
  logic [30:0] ttl_q;
  logic        neg_q;
  logic [1:0]  src_q;
  logic [31:0] handle_q;

  logic [DW-1:0] slot_mem [CAPACITY];
  logic [IW-1:0] rec_mem [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [LW-1:0] entry_count;

  logic [DW-1:0] rd_word;
  logic [IW-1:0] rec_rd;
  logic [IW:0]   cnt;
  logic          pv;
  logic [IW-1:0] pidx;

  logic          found;
  logic [IW-1:0] s_idx;
  logic [IW-1:0] rec_s;
  logic [97:0]   data_s;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] lru_idx;
  logic [IW-1:0] tgt;
  logic          mode_ins;
  logic [LW-1:0] evict_cnt;
  logic [2:0]    res_status;
  logic          lookup_hit;

  logic          mem_we;
  logic [IW-1:0] tgt_sel;
  logic          protect;
  logic [LW-1:0] lim;
  logic          rec_we;
  logic [IW-1:0] rec_wdata;
  logic          v_set;
  logic          v_clear;
  logic          ev_inc;
  logic          last;
  logic [LW-1:0] evict_total;
  logic [2:0]    cls_status;
  logic          cls_start;

  logic        rsp_valid;
  logic [2:0]  rsp_status;
  logic        rsp_neg;
  logic [1:0]  rsp_src;
  logic [31:0] rsp_handle;
  logic [7:0]  rsp_evicted;

  assign req.ready         = (state == IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.hit_negative  = rsp_neg;
  assign rsp.hit_source    = rsp_src;
  assign rsp.hit_handle    = rsp_handle;
  assign rsp.evicted_count = rsp_evicted;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= tlc_pkg::MAX_ENTRIES_RST;
      immutable_mode <= 1'b0;
      stale_window   <= tlc_pkg::STALE_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tlc_pkg::CFG_MAX_ENTRIES:  max_entries    <= cfg_data[7:0];
        tlc_pkg::CFG_IMMUTABLE:    immutable_mode <= cfg_data[0];
        tlc_pkg::CFG_STALE_WINDOW: stale_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    rd_word <= slot_mem[cnt[IW-1:0]];
    if (mem_we) begin
      slot_mem[tgt_sel] <= {key_q, now_q, ttl_q, src_q, neg_q, handle_q};
    end
  end

  always_ff @(posedge clk) begin
    rec_rd <= rec_mem[cnt[IW-1:0]];
    if (rec_we) begin
      rec_mem[pidx] <= rec_wdata;
    end
  end

  always_comb begin
    lim     = (LW'(max_entries) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_entries);
    protect = (src_q == tlc_pkg::SRC_LOCAL) &&
              ((data_s[34:33] == tlc_pkg::SRC_PUBLIC) || (data_s[34:33] == tlc_pkg::SRC_FUSED));
    tgt_sel = found ? s_idx : (free_found ? free_idx : lru_idx);
    mem_we  = (state == DECIDE) && (op_q == tlc_pkg::OP_STORE) && (max_entries != 8'd0) &&
              !(found && protect);
    cls_start = (state == DECIDE) && (op_q == tlc_pkg::OP_LOOKUP) && found;
    last    = pv && (pidx == IW'(CAPACITY - 1));
  end

  // recency sweep
  always_comb begin
    rec_we    = 1'b0;
    rec_wdata = '0;
    v_set     = 1'b0;
    v_clear   = 1'b0;
    ev_inc    = 1'b0;
    if (state == SWEEP && pv) begin
      if (pidx == tgt) begin
        rec_we = 1'b1;
        v_set  = mode_ins;
        ev_inc = mode_ins && valid[pidx];
      end else if (valid[pidx]) begin
        if (mode_ins) begin
          if (LW'(rec_rd) + LW'(1) >= lim) begin
            v_clear = 1'b1;
            ev_inc  = 1'b1;
          end else begin
            rec_we    = 1'b1;
            rec_wdata = rec_rd + IW'(1);
          end
        end else if (rec_rd < rec_s) begin
          rec_we    = 1'b1;
          rec_wdata = rec_rd + IW'(1);
        end
      end
    end
    evict_total = evict_cnt + LW'(ev_inc);
  end

  tlc_classify u_classify (
    .clk          (clk),
    .start        (cls_start),
    .now_sec      (now_q),
    .stamp_sec    (data_s[97:66]),
    .ttl          (data_s[65:35]),
    .stale_window (stale_window),
    .status       (cls_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      valid       <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
      pv          <= 1'b0;
      cnt         <= '0;
    end else begin
      if (rsp_valid && rsp.ready && state != FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            op_q       <= req.op;
            key_q      <= {req.family, req.host_key};
            now_q      <= req.now_sec;
            ttl_q      <= req.ttl_sec;
            neg_q      <= req.negative;
            src_q      <= req.record_source;
            handle_q   <= req.record_handle;
            cnt        <= '0;
            pv         <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          pv   <= (cnt < (IW + 1)'(CAPACITY));
          pidx <= cnt[IW-1:0];
          if (cnt < (IW + 1)'(CAPACITY)) begin
            cnt <= cnt + (IW + 1)'(1);
          end
          if (pv) begin
            if (valid[pidx] && rd_word[130:98] == key_q && !found) begin
              found  <= 1'b1;
              s_idx  <= pidx;
              rec_s  <= rec_rd;
              data_s <= rd_word[97:0];
            end
            if (!valid[pidx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pidx;
            end
            if (valid[pidx] && LW'(rec_rd) == entry_count - LW'(1)) begin
              lru_idx <= pidx;
            end
          end
          if (last) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          cnt        <= '0;
          pv         <= 1'b0;
          evict_cnt  <= '0;
          tgt        <= tgt_sel;
          mode_ins   <= !found;
          lookup_hit <= (op_q == tlc_pkg::OP_LOOKUP) && found;
          if (op_q == tlc_pkg::OP_LOOKUP) begin
            res_status <= tlc_pkg::ST_MISS;
            state      <= found ? SWEEP : FIN;
          end else if (max_entries == 8'd0) begin
            res_status <= tlc_pkg::ST_DISABLED;
            state      <= FIN;
          end else if (found && protect) begin
            res_status <= tlc_pkg::ST_PROTECTED;
            state      <= FIN;
          end else begin
            res_status <= tlc_pkg::ST_STORED;
            state      <= SWEEP;
          end
        end
        SWEEP: begin
          pv   <= (cnt < (IW + 1)'(CAPACITY));
          pidx <= cnt[IW-1:0];
          if (cnt < (IW + 1)'(CAPACITY)) begin
            cnt <= cnt + (IW + 1)'(1);
          end
          if (v_set) begin
            valid[pidx] <= 1'b1;
          end
          if (v_clear) begin
            valid[pidx] <= 1'b0;
          end
          evict_cnt <= evict_total;
          if (last) begin
            if (mode_ins) begin
              entry_count <= entry_count + LW'(1) - evict_total;
            end
            state <= FIN;
          end
        end
        FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            if (lookup_hit) begin
              rsp_status <= immutable_mode ? tlc_pkg::ST_HIT : cls_status;
              rsp_neg    <= data_s[32];
              rsp_src    <= data_s[34:33];
              rsp_handle <= data_s[32] ? 32'd0 : data_s[31:0];
            end else begin
              rsp_status <= res_status;
              rsp_neg    <= 1'b0;
              rsp_src    <= 2'd0;
              rsp_handle <= 32'd0;
            end
            if (res_status == tlc_pkg::ST_STORED && mode_ins) begin
              rsp_evicted <= (evict_cnt > LW'(255)) ? 8'hFF : evict_cnt[7:0];
            end else begin
              rsp_evicted <= 8'd0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hdl/tlc_classify.sv @@
// ----------------------------------------------------------------------------
// tlc_classify
// two-stage age classifier: reciprocal multiply, then ttl and window compares
// ----------------------------------------------------------------------------
module tlc_classify (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] now_sec,
  input  logic [31:0] stamp_sec,
  input  logic [30:0] ttl,
  input  logic [15:0] stale_window,
  output logic [2:0]  status
);

  logic [63:0] prod;
  logic [32:0] age;
  logic [30:0] ttl_r;
  logic [15:0] sw_r;

  logic [tlc_pkg::SOON_W-1:0] soon;
  logic [33:0]                fresh_left;
  logic [33:0]                past_due;
  logic                       before_expiry;

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= 64'({1'b0, ttl}) * 64'(tlc_pkg::RECIP10);
      age   <= {1'b0, now_sec} - {1'b0, stamp_sec};
      ttl_r <= ttl;
      sw_r  <= stale_window;
    end
  end

  always_comb begin
    soon = prod[tlc_pkg::RECIP10_SHIFT +: tlc_pkg::SOON_W];
    if (soon == '0) begin
      soon = tlc_pkg::SOON_W'(1);
    end
    before_expiry = $signed(age) < $signed({2'b00, ttl_r});
    fresh_left    = {3'b000, ttl_r} - {age[32], age};
    past_due      = {age[32], age} - {3'b000, ttl_r};
  end

  always_ff @(posedge clk) begin
    if (before_expiry) begin
      status <= (fresh_left < 34'(soon)) ? tlc_pkg::ST_HIT_SOON : tlc_pkg::ST_HIT;
    end else begin
      status <= (past_due < 34'(sw_r)) ? tlc_pkg::ST_STALE : tlc_pkg::ST_EXPIRED;
    end
  end

endmodule

@@ hdl/tlc_checker.sv @@
// ----------------------------------------------------------------------------
// tlc_checker
// port-level checks for the record cache, bound to the top level
// ----------------------------------------------------------------------------
`include "ttl_lru_record_cache_core_assert.svh"

module tlc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic        hit_negative,
  input logic [1:0]  hit_source,
  input logic [31:0] hit_handle,
  input logic [7:0]  evicted_count
);

  `TLC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "response word dropped while stalled")
  `TLC_ASSERT_NEXT(a_busy, clk, rst, req_valid && req_ready, !req_ready, "request taken while busy")
  `TLC_ASSERT_NOW(a_store_clean, clk, rst, rsp_valid && (status == tlc_pkg::ST_MISS || status == tlc_pkg::ST_STORED || status == tlc_pkg::ST_PROTECTED || status == tlc_pkg::ST_DISABLED), !hit_negative && hit_source == 2'd0 && hit_handle == 32'd0, "hit fields set without a hit")
  `TLC_ASSERT_NOW(a_evict_store, clk, rst, rsp_valid && status != tlc_pkg::ST_STORED, evicted_count == 8'd0, "eviction reported outside a store")

endmodule

bind ttl_lru_record_cache_core tlc_checker u_tlc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .hit_negative  (rsp.hit_negative),
  .hit_source    (rsp.hit_source),
  .hit_handle    (rsp.hit_handle),
  .evicted_count (rsp.evicted_count)
);
